[hdl/h3fd_pkg.sv]
// ----------------------------------------------------------------------------
// h3fd_pkg
// Shared types and constants of the 3D finite difference Hessian unit.
// ----------------------------------------------------------------------------
`default_nettype none

package h3fd_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_X    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Y    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Z    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PADDING   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_X     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_Y     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_Z     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE      = 3'd7;

   // request operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // derivative terms, also the output mode codes
   localparam int TERM_COUNT = 6;
   localparam logic [2:0] TERM_XX = 3'd0;
   localparam logic [2:0] TERM_XY = 3'd1;
   localparam logic [2:0] TERM_XZ = 3'd2;
   localparam logic [2:0] TERM_YY = 3'd3;
   localparam logic [2:0] TERM_YZ = 3'd4;
   localparam logic [2:0] TERM_ZZ = 3'd5;
   localparam logic [2:0] MODE_ALL = 3'd6;

   // neighborhood fetch order
   localparam int NB_COUNT = 19;
   localparam logic [4:0] NB_C      = 5'd0;
   localparam logic [4:0] NB_XA     = 5'd1;
   localparam logic [4:0] NB_XB     = 5'd2;
   localparam logic [4:0] NB_YA     = 5'd3;
   localparam logic [4:0] NB_YB     = 5'd4;
   localparam logic [4:0] NB_ZA     = 5'd5;
   localparam logic [4:0] NB_ZB     = 5'd6;
   localparam logic [4:0] NB_X2Y2   = 5'd7;
   localparam logic [4:0] NB_X2Y1   = 5'd8;
   localparam logic [4:0] NB_X1Y2   = 5'd9;
   localparam logic [4:0] NB_X1Y1   = 5'd10;
   localparam logic [4:0] NB_X2Z2   = 5'd11;
   localparam logic [4:0] NB_X2Z1   = 5'd12;
   localparam logic [4:0] NB_X1Z2   = 5'd13;
   localparam logic [4:0] NB_X1Z1   = 5'd14;
   localparam logic [4:0] NB_Y2Z2   = 5'd15;
   localparam logic [4:0] NB_Y2Z1   = 5'd16;
   localparam logic [4:0] NB_Y1Z2   = 5'd17;
   localparam logic [4:0] NB_Y1Z1   = 5'd18;

   // 48-bit saturation limits (negative limit as magnitude)
   localparam logic [47:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] LIM_NEG = 48'h8000_0000_0000;

   typedef struct packed {
      logic       vld;
      logic [2:0] idx;
      logic       neg;
      logic [1:0] shift;
   } term_ctl_type;

endpackage

`default_nettype wire

[hdl/h3fd_term.sv]
// ----------------------------------------------------------------------------
// h3fd_term
// Scales one difference: magnitude * invA * invB / 2^shift, rounded half
// away from zero, signed and saturated to 48 bits. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module h3fd_term #(
   parameter int DW = 19
) (
   input  logic                   clock,
   input  logic                   reset,
   input  h3fd_pkg::term_ctl_type ctl_in,
   input  logic [DW-1:0]          mag,
   input  logic [15:0]            inv_a,
   input  logic [15:0]            inv_b,
   output h3fd_pkg::term_ctl_type ctl_out,
   output logic [47:0]            result
);
   import h3fd_pkg::*;

   localparam int PW = DW + 32;
   localparam int QW = PW + 1;
   localparam int CW = (QW > 49) ? QW : 49;

   term_ctl_type   s1_ctl_ff, s1_ctl_in, s2_ctl_ff, s3_ctl_ff;
   logic [DW-1:0]  mag_ff;
   logic [31:0]    mult_ff;
   logic [PW-1:0]  prod_ff;
   logic [47:0]    result_ff, result_in;
   logic [QW-1:0]  rnd, sum, q;
   logic [CW-1:0]  qe;

   assign s1_ctl_in = ctl_in;

   always_comb begin
      case (s2_ctl_ff.shift)
         2'd1:    rnd = QW'(1);
         2'd2:    rnd = QW'(2);
         default: rnd = '0;
      endcase
      sum = QW'(prod_ff) + rnd;
      q   = sum >> s2_ctl_ff.shift;
      qe  = CW'(q);
      if (s2_ctl_ff.neg) begin
         if (qe >= CW'(LIM_NEG)) begin
            result_in = LIM_NEG;
         end else begin
            result_in = 48'd0 - qe[47:0];
         end
      end else begin
         if (qe > CW'(LIM_POS)) begin
            result_in = LIM_POS;
         end else begin
            result_in = qe[47:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
      mag_ff    <= mag;
      mult_ff   <= 32'(inv_a) * 32'(inv_b);
      prod_ff   <= PW'(mag_ff) * PW'(mult_ff);
      result_ff <= result_in;
   end

   assign ctl_out = s3_ctl_ff;
   assign result  = result_ff;

endmodule

`default_nettype wire

[hdl/hessian_3d_finite_difference_unit.sv]
// Sequence: a step that finds its output voxel ready runs from the transfer
//   through check, neighbor reads, read wait, terms and emit; a step
//   with nothing to emit goes from check back to idle.
// Throughput: one item at a time; an emitting item is bounded by the 19
//   neighbor reads through the single read port plus six terms through the
//   three-stage scaling pipe. Result stalls stretch the emit state.
// Reset: synchronous; clears the sequencer, positions and registers to their
//   defaults. The plane store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// hessian_3d_finite_difference_unit
// Streaming 3D Hessian by central finite differences over a three-plane
// sample store, raster order in, one voxel result per emitting step out.
// ----------------------------------------------------------------------------
`default_nettype none

module hessian_3d_finite_difference_unit #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [47:0]                    rsp_d_xx,
   output logic signed [47:0]                    rsp_d_xy,
   output logic signed [47:0]                    rsp_d_xz,
   output logic signed [47:0]                    rsp_d_yy,
   output logic signed [47:0]                    rsp_d_yz,
   output logic signed [47:0]                    rsp_d_zz,
   output logic [7:0]                            rsp_voxel_x,
   output logic [7:0]                            rsp_voxel_y,
   output logic [11:0]                           rsp_voxel_z,
   output logic                                  rsp_last_voxel,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [h3fd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [h3fd_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import h3fd_pkg::*;

   localparam int XW          = $clog2(MAX_WIDTH);
   localparam int YW          = $clog2(MAX_HEIGHT);
   localparam int ZW          = 12;
   localparam int PLANE_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int DEPTH       = 3 * PLANE_WORDS;
   localparam int AW          = $clog2(DEPTH);
   localparam int DW          = SAMPLE_BITS + 3;
   localparam int PCW         = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_READ  = 6'b000100,
      S_WAIT  = 6'b001000,
      S_CALC  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [8:0]         size_x_ff, size_y_ff;
   logic [12:0]        size_z_ff;
   logic signed [15:0] padding_ff;
   logic [15:0]        inv_x_ff, inv_y_ff, inv_z_ff;
   logic [2:0]         mode_ff;

   // effective extents, as last index
   logic [XW-1:0] x_last;
   logic [YW-1:0] y_last;
   logic [ZW-1:0] z_last;

   // input and output positions; plane index is z mod 3
   logic [XW-1:0] in_x_ff, out_x_ff;
   logic [YW-1:0] in_y_ff, out_y_ff;
   logic [ZW-1:0] in_z_ff, out_z_ff;
   logic [1:0]    in_p_ff, out_p_ff;
   logic          in_full_ff;

   // plane store
   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] mem_q;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic                          mem_we, req_xfer, emit, last_vox, size_write, ready;

   // neighborhood gather
   logic [4:0]                    rd_cnt_ff;
   logic                          cap_vld_ff;
   logic [4:0]                    cap_idx_ff;
   logic signed [SAMPLE_BITS-1:0] nb_ff [NB_COUNT];

   // neighbor coordinates
   logic [XW-1:0] x1, x2, xs;
   logic [YW-1:0] y1, y2, ys;
   logic [ZW-1:0] z2;
   logic [1:0]    p1, p2, ps;

   // term issue
   logic [2:0]          calc_cnt_ff;
   logic                okx, oky, okz, ok, keep, sh_x, sh_y, sh_z;
   logic signed [DW-1:0] diff;
   logic [DW-1:0]        mag;
   logic [15:0]          inv_a, inv_b;
   term_ctl_type         term_in, term_out;
   logic [47:0]          term_res;
   logic [47:0]          res_ff [TERM_COUNT];

   // result register
   logic rsp_valid_ff;

   function automatic logic [1:0] plane_next(input logic [1:0] p);
      return (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   function automatic logic [1:0] plane_prev(input logic [1:0] p);
      return (p == 2'd0) ? 2'd2 : p - 2'd1;
   endfunction

   function automatic logic above_pad(input logic signed [SAMPLE_BITS-1:0] s,
                                      input logic signed [15:0] pad);
      return PCW'(s) > PCW'(pad);
   endfunction

   // ------------------------------------------------------------------------
   // Effective extents: a size of zero acts as one, larger sizes clamp.
   // ------------------------------------------------------------------------
   always_comb begin
      if (size_x_ff == 9'd0) begin
         x_last = '0;
      end else if (32'(size_x_ff) > MAX_WIDTH) begin
         x_last = XW'(MAX_WIDTH - 1);
      end else begin
         x_last = XW'(size_x_ff - 9'd1);
      end
      if (size_y_ff == 9'd0) begin
         y_last = '0;
      end else if (32'(size_y_ff) > MAX_HEIGHT) begin
         y_last = YW'(MAX_HEIGHT - 1);
      end else begin
         y_last = YW'(size_y_ff - 9'd1);
      end
      if (size_z_ff == 13'd0) begin
         z_last = '0;
      end else if (size_z_ff > 13'd4096) begin
         z_last = 12'd4095;
      end else begin
         z_last = ZW'(size_z_ff - 13'd1);
      end
   end

   assign size_write = csr_write_enable &&
                       (csr_index == CSR_SIZE_X || csr_index == CSR_SIZE_Y ||
                        csr_index == CSR_SIZE_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= 9'd256;
         size_y_ff  <= 9'd256;
         size_z_ff  <= 13'd1;
         padding_ff <= 16'sh8000;
         inv_x_ff   <= 16'd256;
         inv_y_ff   <= 16'd256;
         inv_z_ff   <= 16'd256;
         mode_ff    <= MODE_ALL;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SIZE_X:  size_x_ff  <= csr_write_data[8:0];
            CSR_SIZE_Y:  size_y_ff  <= csr_write_data[8:0];
            CSR_SIZE_Z:  size_z_ff  <= csr_write_data[12:0];
            CSR_PADDING: padding_ff <= csr_write_data;
            CSR_INV_X:   inv_x_ff   <= csr_write_data;
            CSR_INV_Y:   inv_y_ff   <= csr_write_data;
            CSR_INV_Z:   inv_z_ff   <= csr_write_data;
            CSR_MODE:    mode_ff    <= csr_write_data[2:0];
            default:     ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshake. Items are taken only in idle; the sample is written at the
   // transfer edge and all neighbor reads come later, so no read can meet a
   // write to the same entry.
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && (state_ff == S_IDLE);
   assign mem_we    = req_xfer && (req_operation == OP_SAMPLE) && !in_full_ff;
   assign emit      = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign last_vox  = (out_x_ff == x_last) && (out_y_ff == y_last) && (out_z_ff == z_last);

   // clamped neighbor coordinates of the output voxel
   always_comb begin
      x1 = (out_x_ff == '0) ? out_x_ff : out_x_ff - XW'(1);
      x2 = (out_x_ff == x_last) ? out_x_ff : out_x_ff + XW'(1);
      y1 = (out_y_ff == '0) ? out_y_ff : out_y_ff - YW'(1);
      y2 = (out_y_ff == y_last) ? out_y_ff : out_y_ff + YW'(1);
      z2 = (out_z_ff == z_last) ? out_z_ff : out_z_ff + ZW'(1);
      p1 = (out_z_ff == '0) ? out_p_ff : plane_prev(out_p_ff);
      p2 = (out_z_ff == z_last) ? out_p_ff : plane_next(out_p_ff);
   end

   // the far corner of the neighborhood must already be in
   assign ready = in_full_ff || (in_z_ff > z2) ||
                  (in_z_ff == z2 && (in_y_ff > y2 || (in_y_ff == y2 && in_x_ff > x2)));

   // ------------------------------------------------------------------------
   // Positions
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || size_write) begin
         in_x_ff    <= '0;
         in_y_ff    <= '0;
         in_z_ff    <= '0;
         in_p_ff    <= '0;
         in_full_ff <= 1'b0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         out_z_ff   <= '0;
         out_p_ff   <= '0;
      end else begin
         if (mem_we) begin
            if (in_x_ff != x_last) begin
               in_x_ff <= in_x_ff + XW'(1);
            end else begin
               in_x_ff <= '0;
               if (in_y_ff != y_last) begin
                  in_y_ff <= in_y_ff + YW'(1);
               end else begin
                  in_y_ff <= '0;
                  if (in_z_ff != z_last) begin
                     in_z_ff <= in_z_ff + ZW'(1);
                     in_p_ff <= plane_next(in_p_ff);
                  end else begin
                     in_z_ff    <= '0;
                     in_p_ff    <= '0;
                     in_full_ff <= 1'b1;
                  end
               end
            end
         end
         if (emit) begin
            if (last_vox) begin
               // volume done: both sides start over
               in_x_ff    <= '0;
               in_y_ff    <= '0;
               in_z_ff    <= '0;
               in_p_ff    <= '0;
               in_full_ff <= 1'b0;
               out_x_ff   <= '0;
               out_y_ff   <= '0;
               out_z_ff   <= '0;
               out_p_ff   <= '0;
            end else if (out_x_ff != x_last) begin
               out_x_ff <= out_x_ff + XW'(1);
            end else begin
               out_x_ff <= '0;
               if (out_y_ff != y_last) begin
                  out_y_ff <= out_y_ff + YW'(1);
               end else begin
                  out_y_ff <= '0;
                  out_z_ff <= out_z_ff + ZW'(1);
                  out_p_ff <= plane_next(out_p_ff);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Plane store: one write port, one registered read port.
   // ------------------------------------------------------------------------
   always_comb begin
      xs = out_x_ff;
      ys = out_y_ff;
      ps = out_p_ff;
      case (rd_cnt_ff)
         NB_XA:   xs = x1;
         NB_XB:   xs = x2;
         NB_YA:   ys = y1;
         NB_YB:   ys = y2;
         NB_ZA:   ps = p1;
         NB_ZB:   ps = p2;
         NB_X2Y2: begin xs = x2; ys = y2; end
         NB_X2Y1: begin xs = x2; ys = y1; end
         NB_X1Y2: begin xs = x1; ys = y2; end
         NB_X1Y1: begin xs = x1; ys = y1; end
         NB_X2Z2: begin xs = x2; ps = p2; end
         NB_X2Z1: begin xs = x2; ps = p1; end
         NB_X1Z2: begin xs = x1; ps = p2; end
         NB_X1Z1: begin xs = x1; ps = p1; end
         NB_Y2Z2: begin ys = y2; ps = p2; end
         NB_Y2Z1: begin ys = y2; ps = p1; end
         NB_Y1Z2: begin ys = y1; ps = p2; end
         NB_Y1Z1: begin ys = y1; ps = p1; end
         default: ;
      endcase
   end

   assign wr_addr = AW'(32'(in_p_ff) * PLANE_WORDS + 32'(in_y_ff) * MAX_WIDTH + 32'(in_x_ff));
   assign rd_addr = AW'(32'(ps) * PLANE_WORDS + 32'(ys) * MAX_WIDTH + 32'(xs));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_sample;
      end
      mem_q <= mem[rd_addr];
   end

   // gather: read issued one cycle, captured the next
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_vld_ff <= 1'b0;
      end else begin
         cap_vld_ff <= (state_ff == S_READ);
      end
      cap_idx_ff <= rd_cnt_ff;
      if (cap_vld_ff) begin
         nb_ff[cap_idx_ff] <= mem_q;
      end
   end

   // ------------------------------------------------------------------------
   // Term issue: one term per cycle into the shared scaling pipeline.
   // ------------------------------------------------------------------------
   always_comb begin
      okx  = (x_last != '0) && above_pad(nb_ff[NB_XA], padding_ff) &&
             above_pad(nb_ff[NB_XB], padding_ff);
      oky  = (y_last != '0) && above_pad(nb_ff[NB_YA], padding_ff) &&
             above_pad(nb_ff[NB_YB], padding_ff);
      okz  = (z_last != '0) && above_pad(nb_ff[NB_ZA], padding_ff) &&
             above_pad(nb_ff[NB_ZB], padding_ff);
      // interior voxels span two steps, border voxels one
      sh_x = (out_x_ff != '0) && (out_x_ff != x_last);
      sh_y = (out_y_ff != '0) && (out_y_ff != y_last);
      sh_z = (out_z_ff != '0) && (out_z_ff != z_last);

      term_in.vld   = (state_ff == S_CALC) && (calc_cnt_ff != 3'(TERM_COUNT));
      term_in.idx   = calc_cnt_ff;
      term_in.shift = 2'd0;
      case (calc_cnt_ff)
         TERM_XX: begin
            diff  = DW'(nb_ff[NB_XB]) - (DW'(nb_ff[NB_C]) <<< 1) + DW'(nb_ff[NB_XA]);
            inv_a = inv_x_ff;
            inv_b = inv_x_ff;
            ok    = okx;
         end
         TERM_XY: begin
            diff  = DW'(nb_ff[NB_X2Y2]) - DW'(nb_ff[NB_X2Y1]) -
                    DW'(nb_ff[NB_X1Y2]) + DW'(nb_ff[NB_X1Y1]);
            inv_a = inv_x_ff;
            inv_b = inv_y_ff;
            ok    = okx && oky;
            term_in.shift = 2'(sh_x) + 2'(sh_y);
         end
         TERM_XZ: begin
            diff  = DW'(nb_ff[NB_X2Z2]) - DW'(nb_ff[NB_X2Z1]) -
                    DW'(nb_ff[NB_X1Z2]) + DW'(nb_ff[NB_X1Z1]);
            inv_a = inv_x_ff;
            inv_b = inv_z_ff;
            ok    = okx && okz;
            term_in.shift = 2'(sh_x) + 2'(sh_z);
         end
         TERM_YY: begin
            diff  = DW'(nb_ff[NB_YB]) - (DW'(nb_ff[NB_C]) <<< 1) + DW'(nb_ff[NB_YA]);
            inv_a = inv_y_ff;
            inv_b = inv_y_ff;
            ok    = oky;
         end
         TERM_YZ: begin
            diff  = DW'(nb_ff[NB_Y2Z2]) - DW'(nb_ff[NB_Y2Z1]) -
                    DW'(nb_ff[NB_Y1Z2]) + DW'(nb_ff[NB_Y1Z1]);
            inv_a = inv_y_ff;
            inv_b = inv_z_ff;
            ok    = oky && okz;
            term_in.shift = 2'(sh_y) + 2'(sh_z);
         end
         TERM_ZZ: begin
            diff  = DW'(nb_ff[NB_ZB]) - (DW'(nb_ff[NB_C]) <<< 1) + DW'(nb_ff[NB_ZA]);
            inv_a = inv_z_ff;
            inv_b = inv_z_ff;
            ok    = okz;
         end
         default: begin
            diff  = '0;
            inv_a = '0;
            inv_b = '0;
            ok    = 1'b0;
         end
      endcase
      keep        = (mode_ff >= MODE_ALL) || (mode_ff == calc_cnt_ff);
      term_in.neg = diff[DW-1];
      // a term that is off or masked by the mode scales a zero magnitude
      if (ok && keep) begin
         mag = term_in.neg ? DW'(-diff) : DW'(diff);
      end else begin
         mag = '0;
      end
   end

   h3fd_term #(
      .DW(DW)
   ) u_term (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (term_in),
      .mag     (mag),
      .inv_a   (inv_a),
      .inv_b   (inv_b),
      .ctl_out (term_out),
      .result  (term_res)
   );

   always_ff @(posedge clock) begin
      if (term_out.vld) begin
         res_ff[term_out.idx] <= term_res;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_CHECK;
         S_CHECK: state_in = ready ? S_READ : S_IDLE;
         S_READ:  if (rd_cnt_ff == 5'(NB_COUNT - 1)) state_in = S_WAIT;
         S_WAIT:  state_in = S_CALC;
         S_CALC:  if (term_out.vld && term_out.idx == TERM_ZZ) state_in = S_EMIT;
         S_EMIT:  if (emit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_cnt_ff   <= '0;
         calc_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_READ) begin
            rd_cnt_ff <= rd_cnt_ff + 5'd1;
         end else begin
            rd_cnt_ff <= '0;
         end
         if (term_in.vld) begin
            calc_cnt_ff <= calc_cnt_ff + 3'd1;
         end else if (state_ff != S_CALC) begin
            calc_cnt_ff <= '0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result register: lets the next item in while a result waits.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_d_xx       <= res_ff[TERM_XX];
         rsp_d_xy       <= res_ff[TERM_XY];
         rsp_d_xz       <= res_ff[TERM_XZ];
         rsp_d_yy       <= res_ff[TERM_YY];
         rsp_d_yz       <= res_ff[TERM_YZ];
         rsp_d_zz       <= res_ff[TERM_ZZ];
         rsp_voxel_x    <= 8'(out_x_ff);
         rsp_voxel_y    <= 8'(out_y_ff);
         rsp_voxel_z    <= out_z_ff;
         rsp_last_voxel <= last_vox;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_term_in_calc: assert property (@(posedge clock) disable iff (reset)
      term_out.vld |-> state_ff == S_CALC)
      else $error("term result outside calc phase");

   a_full_at_origin: assert property (@(posedge clock) disable iff (reset)
      in_full_ff |-> (in_x_ff == '0 && in_y_ff == '0 && in_z_ff == '0))
      else $error("input position moved after volume complete");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> rd_cnt_ff < 5'(NB_COUNT))
      else $error("neighbor read count overrun");

   a_emit_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && !ready) |=> state_ff == S_IDLE)
      else $error("not-ready step did not return to idle");

endmodule

`default_nettype wire

[sim/hessian_3d_finite_difference_unit_tb.sv]
// ----------------------------------------------------------------------------
// hessian_3d_finite_difference_unit_tb
// Streams whole volumes through the Hessian unit under many register
// settings. A scoreboard predicts each voxel result and checks it field by
// field, while both sides of the link idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module hessian_3d_finite_difference_unit_tb;

   import h3fd_pkg::*;

   localparam int PLANE = 256 * 256;

   typedef struct packed {
      logic [5:0][47:0] d;     // xx, xy, xz, yy, yz, zz
      logic [7:0]       vx;
      logic [7:0]       vy;
      logic [11:0]      vz;
      logic             last;
   } voxel_result_t;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the three-plane store, positions and registers.
   // -------------------------------------------------------------------------
   class hessian_scoreboard;
      int               plane_mem [3*PLANE];
      longint unsigned  in_pos, out_pos;
      logic [8:0]       size_x, size_y;
      logic [12:0]      size_z;
      logic [15:0]      pad_level, inv_x, inv_y, inv_z;
      logic [2:0]       mode;
      voxel_result_t    expected_q [$];
      int               errors;

      function new();
         in_pos = 0; out_pos = 0;
         size_x = 256; size_y = 256; size_z = 1;
         pad_level = 16'h8000;
         inv_x = 256; inv_y = 256; inv_z = 256;
         mode = MODE_ALL;
         errors = 0;
      endfunction

      function void apply_write(logic [2:0] idx, logic [15:0] data);
         case (idx)
            CSR_SIZE_X: begin size_x = data[8:0];  in_pos = 0; out_pos = 0; end
            CSR_SIZE_Y: begin size_y = data[8:0];  in_pos = 0; out_pos = 0; end
            CSR_SIZE_Z: begin size_z = data[12:0]; in_pos = 0; out_pos = 0; end
            CSR_PADDING: pad_level = data;
            CSR_INV_X:   inv_x = data;
            CSR_INV_Y:   inv_y = data;
            CSR_INV_Z:   inv_z = data;
            CSR_MODE:    mode = data[2:0];
            default: ;
         endcase
      endfunction

      function longint unsigned ext_x();
         return size_x == 0 ? 1 : (size_x > 256 ? 256 : size_x);
      endfunction
      function longint unsigned ext_y();
         return size_y == 0 ? 1 : (size_y > 256 ? 256 : size_y);
      endfunction
      function longint unsigned ext_z();
         return size_z == 0 ? 1 : (size_z > 4096 ? 4096 : size_z);
      endfunction
      function longint unsigned voxel_count();
         return ext_x() * ext_y() * ext_z();
      endfunction
      function bit busy();
         return in_pos != 0 || out_pos != 0;
      endfunction

      function int cell_at(longint unsigned x, longint unsigned y, longint unsigned z);
         return plane_mem[(z % 3) * PLANE + y * 256 + x];
      endfunction

      // diff * mult / div, ties away from zero, clipped to 48 bits signed
      function logic [47:0] scale_term(longint diff, longint unsigned mult,
                                       longint unsigned div);
         bit              neg;
         longint unsigned mag, q;
         longint          r;
         neg = diff < 0;
         mag = neg ? -diff : diff;
         if (mult == 0 || mag == 0) return '0;
         if (mag > (64'd1 << 62) / mult) q = LIM_NEG;
         else q = (mag * mult + div / 2) / div;
         if (neg) r = (q >= LIM_NEG) ? -longint'(LIM_NEG) : -longint'(q);
         else     r = (q > LIM_POS) ? longint'(LIM_POS) : longint'(q);
         return r[47:0];
      endfunction

      // accepted input transfer: store sample, predict at most one voxel
      function void note_item(logic op, logic signed [15:0] smp);
         longint unsigned nx, ny, nz, total, o, x, y, z;
         longint unsigned x1, x2, y1, y2, z1, z2;
         int              pad, c, xa, xb, ya, yb, za, zb;
         bit              okx, oky, okz;
         logic [5:0][47:0] d;
         voxel_result_t   res;
         nx = ext_x(); ny = ext_y(); nz = ext_z();
         total = nx * ny * nz;
         if (op == OP_SAMPLE && in_pos < total) begin
            plane_mem[((in_pos / (nx * ny)) % 3) * PLANE + ((in_pos / nx) % ny) * 256
                      + in_pos % nx] = smp;
            in_pos++;
         end
         o = out_pos;
         if (o >= total) return;
         x = o % nx; y = (o / nx) % ny; z = o / (nx * ny);
         x1 = x ? x - 1 : 0; x2 = (x + 1 < nx) ? x + 1 : nx - 1;
         y1 = y ? y - 1 : 0; y2 = (y + 1 < ny) ? y + 1 : ny - 1;
         z1 = z ? z - 1 : 0; z2 = (z + 1 < nz) ? z + 1 : nz - 1;
         // neighborhood not complete yet
         if (in_pos <= z2 * nx * ny + y2 * nx + x2) return;
         pad = int'($signed(pad_level));
         c  = cell_at(x, y, z);
         xa = cell_at(x1, y, z); xb = cell_at(x2, y, z);
         ya = cell_at(x, y1, z); yb = cell_at(x, y2, z);
         za = cell_at(x, y, z1); zb = cell_at(x, y, z2);
         okx = nx > 1 && xa > pad && xb > pad;
         oky = ny > 1 && ya > pad && yb > pad;
         okz = nz > 1 && za > pad && zb > pad;
         d = '0;
         if (okx) d[TERM_XX] = scale_term(xb - 2 * c + xa, inv_x * inv_x, 1);
         if (okx && oky)
            d[TERM_XY] = scale_term(cell_at(x2, y2, z) - cell_at(x2, y1, z)
                                    - cell_at(x1, y2, z) + cell_at(x1, y1, z),
                                    inv_x * inv_y, (x2 - x1) * (y2 - y1));
         if (okx && okz)
            d[TERM_XZ] = scale_term(cell_at(x2, y, z2) - cell_at(x2, y, z1)
                                    - cell_at(x1, y, z2) + cell_at(x1, y, z1),
                                    inv_x * inv_z, (x2 - x1) * (z2 - z1));
         if (oky) d[TERM_YY] = scale_term(yb - 2 * c + ya, inv_y * inv_y, 1);
         if (oky && okz)
            d[TERM_YZ] = scale_term(cell_at(x, y2, z2) - cell_at(x, y2, z1)
                                    - cell_at(x, y1, z2) + cell_at(x, y1, z1),
                                    inv_y * inv_z, (y2 - y1) * (z2 - z1));
         if (okz) d[TERM_ZZ] = scale_term(zb - 2 * c + za, inv_z * inv_z, 1);
         for (int j = 0; j < TERM_COUNT; j++)
            if (!(mode >= MODE_ALL || j == mode)) d[j] = '0;
         res.d = d;
         res.vx = x[7:0]; res.vy = y[7:0]; res.vz = z[11:0];
         res.last = (o + 1 == total);
         expected_q.push_back(res);
         out_pos++;
         if (out_pos >= total) begin
            out_pos = 0;
            in_pos = 0;
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(voxel_result_t got);
         voxel_result_t want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result transfer, voxel_x", 64'(got.vx), 64'd0);
            return;
         end
         want = expected_q.pop_front();
         for (int j = 0; j < TERM_COUNT; j++)
            if (got.d[j] !== want.d[j])
               report_mismatch($sformatf("term %0d at (%0d,%0d,%0d)", j, want.vx,
                                         want.vy, want.vz), 64'(got.d[j]), 64'(want.d[j]));
         if (got.vx !== want.vx) report_mismatch("voxel_x", 64'(got.vx), 64'(want.vx));
         if (got.vy !== want.vy) report_mismatch("voxel_y", 64'(got.vy), 64'(want.vy));
         if (got.vz !== want.vz) report_mismatch("voxel_z", 64'(got.vz), 64'(want.vz));
         if (got.last !== want.last)
            report_mismatch("last_voxel", 64'(got.last), 64'(want.last));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_operation = OP_SAMPLE;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [47:0] rsp_d_xx, rsp_d_xy, rsp_d_xz, rsp_d_yy, rsp_d_yz, rsp_d_zz;
   logic [7:0]         rsp_voxel_x, rsp_voxel_y;
   logic [11:0]        rsp_voxel_z;
   logic               rsp_last_voxel;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = CSR_SIZE_X;
   logic [15:0]        csr_write_data = '0;

   hessian_3d_finite_difference_unit u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_operation, .req_sample,
      .rsp_valid, .rsp_stall,
      .rsp_d_xx, .rsp_d_xy, .rsp_d_xz, .rsp_d_yy, .rsp_d_yz, .rsp_d_zz,
      .rsp_voxel_x, .rsp_voxel_y, .rsp_voxel_z, .rsp_last_voxel,
      .csr_write_enable, .csr_index, .csr_write_data
   );

   always #5 clock = ~clock;

   hessian_scoreboard sb = new();

   int send_gap_pct  = 0;    // chance of a gap before a request transfer
   int rsp_stall_pct = 0;    // chance of stalling a result cycle
   int items_sent    = 0;
   int results_seen  = 0;
   int volumes_done  = 0;

   // -------------------------------------------------------------------------
   // Result side: check each transfer, then pick the next stall value.
   // Once, after 60 results, hold the result side stalled so the unit backs up
   // into its request channel while the sender keeps offering.
   // -------------------------------------------------------------------------
   int hold_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result('{d: {rsp_d_zz, rsp_d_yz, rsp_d_yy, rsp_d_xz, rsp_d_xy,
                                  rsp_d_xx},
                              vx: rsp_voxel_x, vy: rsp_voxel_y, vz: rsp_voxel_z,
                              last: rsp_last_voxel});
            results_seen++;
            if (results_seen == 60) hold_left = 400;
         end
         if (hold_left == 0 && $urandom_range(0, 199) == 0)
            hold_left = $urandom_range(10, 40);       // occasional long stall
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   function int pick_gap();
      if ($urandom_range(0, 99) >= send_gap_pct) return 0;
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // one request transfer; returns at the edge where it is accepted
   task send_item(logic op, logic [15:0] smp);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample    <= smp;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, smp);
      items_sent++;
   endtask

   // unit idle: nothing owed, then room for a trailing non-emitting step
   task wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // program all registers back to back, enable held high throughout
   task program_regs(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                     logic [15:0] pad, logic [15:0] ix, logic [15:0] iy,
                     logic [15:0] iz, logic [15:0] md);
      logic [7:0][15:0] vals;
      vals = {md, iz, iy, ix, pad, sz, sy, sx};
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= i[2:0];
         csr_write_data   <= vals[i];
         @(posedge clock);
         sb.apply_write(i[2:0], vals[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   function logic [15:0] rand16();
      return 16'($urandom_range(0, 65535));
   endfunction

   // sample value for one voxel; pattern 1 swings between full-scale extremes
   function logic [15:0] pick_sample(int pattern, int n);
      case (pattern)
         1:       return n[0] ? 16'h8001 : 16'h7FFF;
         2:       return ($urandom_range(0, 3) == 0) ? 16'h8000 : rand16();
         default: return ($urandom_range(0, 1)) ? rand16()
                                                : 16'(int'($urandom_range(0, 400)) - 200);
      endcase
   endfunction

   // one full volume: samples with stray flushes, then flushes and surplus
   // samples until the last voxel is out
   task run_volume(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                   logic [15:0] pad, logic [15:0] ix, logic [15:0] iy,
                   logic [15:0] iz, logic [15:0] md, int pattern, int flush_pct);
      longint unsigned total;
      program_regs(sx, sy, sz, pad, ix, iy, iz, md);
      total = sb.voxel_count();
      for (longint unsigned n = 0; n < total; ) begin
         if ($urandom_range(0, 99) < flush_pct) begin
            send_item(OP_FLUSH, rand16());
         end else begin
            send_item(OP_SAMPLE, pick_sample(pattern, int'(n)));
            n++;
         end
      end
      while (sb.busy())
         send_item($urandom_range(0, 2) == 0 ? OP_SAMPLE : OP_FLUSH, rand16());
      wait_drained();
      volumes_done++;
   endtask

   function logic [15:0] pick_inv();
      case ($urandom_range(0, 5))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         2:       return 16'($urandom_range(1, 65535));
         default: return 16'($urandom_range(64, 1024));
      endcase
   endfunction

   initial begin
      int iter;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero sizes act as one voxel, mode 7 acts as all
      run_volume(16'd0, 16'd0, 16'd0, 16'h8000, 16'd256, 16'd256, 16'd256,
                 16'd7, 0, 30);
      // directed: full-scale swings with max inverse spacing -> saturation
      run_volume(16'd3, 16'd2, 16'd2, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'(MODE_ALL), 1, 0);
      // directed: padding at -32768 zeroes terms around dark voxels
      run_volume(16'd2, 16'd2, 16'd2, 16'h8000, 16'd256, 16'd512, 16'd128,
                 16'(TERM_XY), 2, 10);

      // random volumes, mostly small; the first one is a full-width row that
      // covers the x coordinate range and the oversize clamp
      iter = 0;
      while (items_sent < 470) begin
         send_gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
         rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
         if (iter == 0)
            run_volume(16'd300 | 16'($urandom_range(0, 127) << 9), 16'd1, 16'd1,
                       16'h8000, pick_inv(), pick_inv(), pick_inv(), 16'(MODE_ALL),
                       0, 5);
         else
            run_volume(16'($urandom_range(1, 8) | ($urandom_range(0, 127) << 9)),
                       16'($urandom_range(1, 6) | ($urandom_range(0, 127) << 9)),
                       16'($urandom_range(1, 5) | ($urandom_range(0, 7) << 13)),
                       ($urandom_range(0, 2) == 0) ? rand16() : 16'h8000,
                       pick_inv(), pick_inv(), pick_inv(),
                       16'($urandom_range(0, 7) | ($urandom_range(0, 8191) << 3)),
                       $urandom_range(0, 2), $urandom_range(0, 20));
         iter++;
      end

      wait_drained();
      $display("Covered %0d volumes, %0d request transfers, %0d voxel results,",
               volumes_done, items_sent, results_seen);
      $display("with random idling, long result stalls and full register sweeps.");
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog
   initial begin
      #60000000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
